FILE: src/spi_target_length_prefixed_frame_unit_assert.svh
// ----------------------------------------------------------------------------
// SPI target assertion macros
// Shorthand for clocked concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SPI_TARGET_LENGTH_PREFIXED_FRAME_UNIT_ASSERT_SVH
`define SPI_TARGET_LENGTH_PREFIXED_FRAME_UNIT_ASSERT_SVH

// Checked at every edge, reset included.
`define STLPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while out of reset.
`define STLPF_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: src/stlpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI target package
// Shared constants, register codes and the result record.
// ----------------------------------------------------------------------------
package stlpf_pkg;

  localparam int DEFAULT_HEADER_BITS    = 8;
  localparam int DEFAULT_MAX_FRAME_BITS = 32;

  localparam int WORD_W = 32;  // reply and received word width
  localparam int LEN_W  = 6;   // fallback length and frame_bits width

  localparam logic [WORD_W-1:0] REPLY_WORD_RESET   = 32'h0000_0055;
  localparam logic [LEN_W-1:0]  FALLBACK_LEN_RESET = 6'd8;
  localparam int                FRAME_LEN_RESET    = 8;

  // Register select, taken from paddr[2]
  localparam logic REG_REPLY_WORD   = 1'b0;
  localparam logic REG_FALLBACK_LEN = 1'b1;

  typedef struct packed {
    logic              data_out;
    logic              frame_done;
    logic [WORD_W-1:0] received_word;
    logic [LEN_W-1:0]  frame_bits;
    logic              length_invalid;
  } stlpf_result_t;

endpackage
`default_nettype wire

FILE: src/stlpf_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI target frame engine
// Level-wait sequencer: select, header, full-duplex transfer, deselect.
// ----------------------------------------------------------------------------
module stlpf_core #(
  parameter int HEADER_BITS    = 8,
  parameter int MAX_FRAME_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        sclk,
  input  logic                        seln,
  input  logic                        din,
  input  logic [31:0]                 reply_word,
  input  logic [5:0]                  fallback_length,
  output stlpf_pkg::stlpf_result_t    result
);
  import stlpf_pkg::*;

  localparam int BI_CNT = (HEADER_BITS > MAX_FRAME_BITS) ? HEADER_BITS : MAX_FRAME_BITS;
  localparam int BI_W   = (BI_CNT > 1) ? $clog2(BI_CNT) : 1;
  localparam int FL_W   = $clog2(MAX_FRAME_BITS + 1);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_HDR_HIGH   = 3'd1;
  localparam logic [2:0] PH_HDR_LOW    = 3'd2;
  localparam logic [2:0] PH_XFER_HIGH  = 3'd3;
  localparam logic [2:0] PH_XFER_LOW   = 3'd4;
  localparam logic [2:0] PH_WAIT_DESEL = 3'd5;

  logic [2:0]             phase_r,        phase_nxt;
  logic [BI_W-1:0]        bit_index_r,    bit_index_nxt;
  logic [HEADER_BITS-1:0] header_shift_r, header_shift_nxt;
  logic [WORD_W-1:0]      data_shift_r,   data_shift_nxt;
  logic [FL_W-1:0]        frame_length_r, frame_length_nxt;
  logic                   out_bit_r,      out_bit_nxt;
  logic                   bad_length_r,   bad_length_nxt;
  logic                   done;

  logic [HEADER_BITS:0]   hdr_ext;
  logic                   hdr_ok;
  logic [6:0]             fb_clamp;
  logic [FL_W-1:0]        fl_new;
  logic [WORD_W-1:0]      reply_sh;
  logic [FL_W+5:0]        fl_ext;

  assign hdr_ext = {header_shift_r, din};
  assign hdr_ok  = (header_shift_r != '0) &&
                   (32'(header_shift_r) <= 32'(MAX_FRAME_BITS));

  // Fallback is clamped into 1..MAX_FRAME_BITS
  always_comb begin
    fb_clamp = {1'b0, fallback_length};
    if (fb_clamp == 7'd0) begin
      fb_clamp = 7'd1;
    end else if (fb_clamp > 7'(MAX_FRAME_BITS)) begin
      fb_clamp = 7'(MAX_FRAME_BITS);
    end
  end

  assign fl_new   = hdr_ok ? FL_W'(header_shift_r) : FL_W'(fb_clamp);
  // Shift by 32 or more yields zero, which is the reply for positions past the word
  assign reply_sh = reply_word >> bit_index_nxt;

  always_comb begin
    phase_nxt        = phase_r;
    bit_index_nxt    = bit_index_r;
    header_shift_nxt = header_shift_r;
    data_shift_nxt   = data_shift_r;
    frame_length_nxt = frame_length_r;
    bad_length_nxt   = bad_length_r;
    done             = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (!seln) begin
          header_shift_nxt = '0;
          bit_index_nxt    = BI_W'(HEADER_BITS - 1);
          phase_nxt        = PH_HDR_HIGH;
        end
      end
      PH_HDR_HIGH: begin
        if (sclk) begin
          header_shift_nxt = hdr_ext[HEADER_BITS-1:0];
          phase_nxt        = PH_HDR_LOW;
        end
      end
      PH_HDR_LOW: begin
        if (!sclk) begin
          if (bit_index_r != '0) begin
            bit_index_nxt = bit_index_r - 1'b1;
            phase_nxt     = PH_HDR_HIGH;
          end else begin
            frame_length_nxt = fl_new;
            bad_length_nxt   = !hdr_ok;
            data_shift_nxt   = '0;
            bit_index_nxt    = BI_W'(fl_new - 1'b1);
            phase_nxt        = PH_XFER_HIGH;
          end
        end
      end
      PH_XFER_HIGH: begin
        if (sclk) begin
          data_shift_nxt = {data_shift_r[WORD_W-2:0], din};
          phase_nxt      = PH_XFER_LOW;
        end
      end
      PH_XFER_LOW: begin
        if (!sclk) begin
          if (bit_index_r != '0) begin
            bit_index_nxt = bit_index_r - 1'b1;
            phase_nxt     = PH_XFER_HIGH;
          end else begin
            phase_nxt = PH_WAIT_DESEL;
          end
        end
      end
      PH_WAIT_DESEL: begin
        if (seln) begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // A new reply bit is loaded whenever a bit period starts on a low clock
  always_comb begin
    out_bit_nxt = out_bit_r;
    if (!sclk && ((phase_r == PH_HDR_LOW && bit_index_r == '0) ||
                  (phase_r == PH_XFER_LOW && bit_index_r != '0))) begin
      out_bit_nxt = reply_sh[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      bit_index_r    <= '0;
      header_shift_r <= '0;
      data_shift_r   <= '0;
      frame_length_r <= FL_W'(FRAME_LEN_RESET);
      out_bit_r      <= 1'b0;
      bad_length_r   <= 1'b0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      bit_index_r    <= bit_index_nxt;
      header_shift_r <= header_shift_nxt;
      data_shift_r   <= data_shift_nxt;
      frame_length_r <= frame_length_nxt;
      out_bit_r      <= out_bit_nxt;
      bad_length_r   <= bad_length_nxt;
    end
  end

  assign fl_ext = (FL_W + 6)'(frame_length_nxt);

  always_comb begin
    result.data_out       = out_bit_nxt;
    result.frame_done     = done;
    result.received_word  = data_shift_nxt;
    result.frame_bits     = fl_ext[5:0];
    result.length_invalid = bad_length_nxt;
  end

endmodule
`default_nettype wire

FILE: src/stlpf_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI target result stage
// Output register with one skid entry so input keeps flowing on a stall.
// ----------------------------------------------------------------------------
module stlpf_out_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  stlpf_pkg::stlpf_result_t push_data,
  output logic                     can_push,
  output logic                     out_valid,
  input  logic                     out_ready,
  output stlpf_pkg::stlpf_result_t out_data
);
  import stlpf_pkg::*;

  logic          out_vld_r,  out_vld_nxt;
  logic          skid_vld_r, skid_vld_nxt;
  stlpf_result_t out_r,      out_nxt;
  stlpf_result_t skid_r,     skid_nxt;
  logic          pop;

  assign pop = out_vld_r && out_ready;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    priority if (skid_vld_r) begin
      if (pop) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_nxt     = push_data;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign can_push  = !skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: src/spi_target_length_prefixed_frame_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI target, length-prefixed frame, oversampled pins
// Result path: an accepted sample's result is registered in the output
//   register, or in the skid entry while the output stalls. Throughput: one
//   sample transaction per cycle while in_ready is high; the skid entry absorbs
//   one stalled result, so in_ready drops only with two results waiting.
// Reset (rst_n low, synchronous): engine idles waiting for select, the
//   registers return to reply 0x55 and fallback 8, output queue empties.
// ----------------------------------------------------------------------------
module spi_target_length_prefixed_frame_unit #(
  parameter int HEADER_BITS    = stlpf_pkg::DEFAULT_HEADER_BITS,
  parameter int MAX_FRAME_BITS = stlpf_pkg::DEFAULT_MAX_FRAME_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_sclk_level,
  input  logic        in_select_n_level,
  input  logic        in_data_in_level,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_data_out,
  output logic        out_frame_done,
  output logic [31:0] out_received_word,
  output logic [5:0]  out_frame_bits,
  output logic        out_length_invalid,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stlpf_pkg::*;

  logic [WORD_W-1:0] reply_word_r;
  logic [LEN_W-1:0]  fallback_length_r;
  logic              cfg_wr;
  logic              in_xact;
  stlpf_result_t     core_res;
  stlpf_result_t     out_res;

  // ---- configuration registers ----
  // Zero-wait port; paddr[2] picks the register, low address bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_word_r      <= REPLY_WORD_RESET;
      fallback_length_r <= FALLBACK_LEN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_REPLY_WORD:   reply_word_r      <= pwdata;
        REG_FALLBACK_LEN: fallback_length_r <= pwdata[LEN_W-1:0];
        default:          reply_word_r      <= reply_word_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_REPLY_WORD:   prdata = reply_word_r;
      REG_FALLBACK_LEN: prdata = 32'(fallback_length_r);
      default:          prdata = '0;
    endcase
  end

  // ---- frame engine: advances once per accepted sample transaction ----
  assign in_xact = in_valid && in_ready;

  stlpf_core #(
    .HEADER_BITS    (HEADER_BITS),
    .MAX_FRAME_BITS (MAX_FRAME_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_xact),
    .sclk            (in_sclk_level),
    .seln            (in_select_n_level),
    .din             (in_data_in_level),
    .reply_word      (reply_word_r),
    .fallback_length (fallback_length_r),
    .result          (core_res)
  );

  // ---- result register plus skid entry ----
  stlpf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xact),
    .push_data (core_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_data_out       = out_res.data_out;
  assign out_frame_done     = out_res.frame_done;
  assign out_received_word  = out_res.received_word;
  assign out_frame_bits     = out_res.frame_bits;
  assign out_length_invalid = out_res.length_invalid;

endmodule
`default_nettype wire

FILE: src/stlpf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI target port checker
// Watches the top-level channels for queueing and reset slips.
// ----------------------------------------------------------------------------
`include "spi_target_length_prefixed_frame_unit_assert.svh"

module stlpf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_data_out,
  input logic        out_frame_done,
  input logic [31:0] out_received_word,
  input logic [5:0]  out_frame_bits,
  input logic        out_length_invalid
);

  // whole result payload, for the hold check
  logic [40:0] out_payload;

  assign out_payload = {out_data_out, out_frame_done, out_received_word,
                        out_frame_bits, out_length_invalid};

  // reset empties the output queue
  `STLPF_ASSERT(a_reset_empty, (!rst_n) |=> (!out_valid), "output valid after reset")

  // a transaction always leaves a result presented on the next cycle
  `STLPF_ASSERT_RUN(a_result_follows, (in_valid && in_ready) |=> out_valid, "result missing")

  // input back-pressure only with a result held at the output
  `STLPF_ASSERT_RUN(a_stall_cause, (!in_ready) |-> out_valid, "in_ready low with empty output")

  // a stalled result holds
  `STLPF_ASSERT_RUN(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_payload)), "stalled result changed")

endmodule

bind spi_target_length_prefixed_frame_unit stlpf_checker u_checker (.*);
`default_nettype wire
